### rtl/efr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efr_pkg: shared types and constants of the escaped frame receiver
// Widths, framing bytes, status codes, item structs and the
// controller/datapath interface.
// ----------------------------------------------------------------------------
package efr_pkg;

    localparam int EFR_MAX_PAYLOAD = 32;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 6;
    localparam int STATUS_W = 3;

    localparam logic [BYTE_W-1:0] GUARD_BYTE     = 8'h00;
    localparam logic [BYTE_W-1:0] ESC_GUARD_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE    = 8'hAA;

    localparam logic [LEN_W-1:0] LEN_RESET = 6'd1;

    localparam logic [STATUS_W-1:0] FS_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] FS_LINE   = 3'd1;
    localparam logic [STATUS_W-1:0] FS_GUARD  = 3'd2;
    localparam logic [STATUS_W-1:0] FS_ESCAPE = 3'd3;
    localparam logic [STATUS_W-1:0] FS_NOEND  = 3'd4;
    localparam logic [STATUS_W-1:0] FS_CHECK  = 3'd5;

    typedef enum logic [2:0] {
        S_HUNT,
        S_SKIP,
        S_BODY,
        S_ESC,
        S_END,
        S_DRN_RD,
        S_DRN_OUT,
        S_DRN_STAT
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              line_error;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                is_status;
        logic [STATUS_W-1:0] frame_status;
        logic                last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic                in_ready;
        logic                clear_frame;
        logic                store;
        logic                store_unesc;
        logic                emit_status;
        logic [STATUS_W-1:0] status_code;
        logic                emit_byte;
        logic                rd_clear;
        logic                rd_next;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic line_err;
        logic is_guard;
        logic is_escape;
        logic is_esc_guard;
        logic out_free;
        logic count_ge_len;
        logic xor_zero;
        logic rd_last;
    } t_ctrl_stat;

endpackage
`default_nettype wire

### rtl/efr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efr_ctrl: frame receiver controller
// Phase state machine: hunt, skip guards, body, escape, end guard, and the
// drain sequence that sends a good frame's payload and its ok status.
// ----------------------------------------------------------------------------
module efr_ctrl
    import efr_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_ctrl_stat i_stat,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   produce;
    logic   take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        produce = 1'b0;
        take    = 1'b0;

        unique case (r_state)
            S_HUNT, S_SKIP, S_BODY, S_ESC, S_END: begin
                // an item that yields a result needs the output slot
                produce = i_stat.line_err
                       || (r_state == S_BODY && i_stat.is_guard)
                       || (r_state == S_ESC && !i_stat.is_escape && !i_stat.is_esc_guard)
                       || (r_state == S_END);
                o_cmd.in_ready = i_stat.out_free || !produce;
                take = i_stat.in_valid && o_cmd.in_ready;
            end
            default: begin
                o_cmd.in_ready = 1'b0;
            end
        endcase

        unique case (r_state)
            S_DRN_RD: begin
                n_state = S_DRN_OUT;
            end
            S_DRN_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_byte = 1'b1;
                    o_cmd.rd_next   = 1'b1;
                    n_state = i_stat.rd_last ? S_DRN_STAT : S_DRN_RD;
                end
            end
            S_DRN_STAT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_status = 1'b1;
                    o_cmd.status_code = FS_OK;
                    n_state = S_HUNT;
                end
            end
            default: begin
                if (take) begin
                    if (i_stat.line_err) begin
                        o_cmd.emit_status = 1'b1;
                        o_cmd.status_code = FS_LINE;
                        n_state = S_HUNT;
                    end else begin
                        unique case (r_state)
                            S_SKIP, S_BODY: begin
                                if (i_stat.is_guard) begin
                                    if (r_state == S_BODY) begin
                                        o_cmd.emit_status = 1'b1;
                                        o_cmd.status_code = FS_GUARD;
                                        n_state = S_HUNT;
                                    end
                                end else if (i_stat.is_escape) begin
                                    n_state = S_ESC;
                                end else begin
                                    o_cmd.store = 1'b1;
                                    n_state = i_stat.count_ge_len ? S_END : S_BODY;
                                end
                            end
                            S_ESC: begin
                                if (i_stat.is_escape || i_stat.is_esc_guard) begin
                                    o_cmd.store       = 1'b1;
                                    o_cmd.store_unesc = 1'b1;
                                    n_state = i_stat.count_ge_len ? S_END : S_BODY;
                                end else begin
                                    o_cmd.emit_status = 1'b1;
                                    o_cmd.status_code = FS_ESCAPE;
                                    n_state = S_HUNT;
                                end
                            end
                            S_END: begin
                                if (!i_stat.is_guard) begin
                                    o_cmd.emit_status = 1'b1;
                                    o_cmd.status_code = FS_NOEND;
                                    n_state = S_HUNT;
                                end else if (!i_stat.xor_zero) begin
                                    o_cmd.emit_status = 1'b1;
                                    o_cmd.status_code = FS_CHECK;
                                    n_state = S_HUNT;
                                end else begin
                                    o_cmd.rd_clear = 1'b1;
                                    n_state = S_DRN_RD;
                                end
                            end
                            default: begin
                                // hunting: a guard opens a frame
                                if (i_stat.is_guard) begin
                                    o_cmd.clear_frame = 1'b1;
                                    n_state = S_SKIP;
                                end
                            end
                        endcase
                    end
                end
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.emit_status && o_cmd.emit_byte))
        else $error("status and payload emitted in the same cycle");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_status || o_cmd.emit_byte) |-> i_stat.out_free)
        else $error("result emitted into a full output slot");

    a_drain_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRN_RD || r_state == S_DRN_OUT || r_state == S_DRN_STAT)
        |-> (!o_cmd.in_ready && !o_cmd.store))
        else $error("input taken during drain");

    a_drain_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_clear |=> (r_state == S_DRN_RD))
        else $error("drain not started after good frame");
`endif

endmodule
`default_nettype wire

### rtl/efr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efr_dp: frame receiver datapath
// Length register, byte count, running XOR, payload memory with registered
// read port, drain pointer and the output register.
// ----------------------------------------------------------------------------
module efr_dp
    import efr_pkg::*;
#(
    parameter int MAX_PAYLOAD = EFR_MAX_PAYLOAD
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_wr_en,
    input  wire  [LEN_W-1:0] i_cfg_wr_data,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output t_out_item        o_out_data,
    input  t_ctrl_cmd        i_cmd,
    output t_ctrl_stat       o_stat
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    logic [LEN_W-1:0]  r_cfg_len;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  r_count;
    logic [BYTE_W-1:0] r_xor;
    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] r_rd_data;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW-1:0]     last_ptr;
    logic              r_out_valid;
    t_out_item         r_out;
    logic [BYTE_W-1:0] store_val;
    logic              count_ge_len;
    logic              out_free;

    always_comb begin
        if (r_cfg_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_cfg_len > MAX_LEN) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = r_cfg_len;
        end
    end

    assign count_ge_len = (r_count >= eff_len);
    assign last_ptr     = AW'(eff_len - LEN_W'(1));
    assign out_free     = !r_out_valid || !i_out_stall;

    // unescaped value: escape pair gives 0xAA, escaped guard gives 0x00
    always_comb begin
        if (!i_cmd.store_unesc) begin
            store_val = i_in_data.in_byte;
        end else if (i_in_data.in_byte == ESCAPE_BYTE) begin
            store_val = ESCAPE_BYTE;
        end else begin
            store_val = GUARD_BYTE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg_len <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_xor   <= '0;
        end else if (i_cmd.clear_frame) begin
            r_count <= '0;
            r_xor   <= '0;
        end else if (i_cmd.store) begin
            r_count <= r_count + LEN_W'(1);
            r_xor   <= r_xor ^ store_val;
        end
    end

    // checksum byte and anything past the length is not kept
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && !count_ge_len) begin
            r_mem[r_count[AW-1:0]] <= store_val;
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
        end else if (i_cmd.rd_clear) begin
            r_rd_ptr <= '0;
        end else if (i_cmd.rd_next) begin
            r_rd_ptr <= r_rd_ptr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_status || i_cmd.emit_byte) begin
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_status) begin
            r_out.out_byte     <= '0;
            r_out.is_status    <= 1'b1;
            r_out.frame_status <= i_cmd.status_code;
            r_out.last         <= 1'b1;
        end else if (i_cmd.emit_byte) begin
            r_out.out_byte     <= r_rd_data;
            r_out.is_status    <= 1'b0;
            r_out.frame_status <= FS_OK;
            r_out.last         <= 1'b0;
        end
    end

    assign o_in_stall  = !i_cmd.in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_stat.in_valid     = i_in_valid;
        o_stat.line_err     = i_in_data.line_error;
        o_stat.is_guard     = (i_in_data.in_byte == GUARD_BYTE);
        o_stat.is_escape    = (i_in_data.in_byte == ESCAPE_BYTE);
        o_stat.is_esc_guard = (i_in_data.in_byte == ESC_GUARD_BYTE);
        o_stat.out_free     = out_free;
        o_stat.count_ge_len = count_ge_len;
        o_stat.xor_zero     = (r_xor == '0);
        o_stat.rd_last      = (r_rd_ptr == last_ptr);
    end

`ifndef ASSERT_OFF
    a_last_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.last == r_out.is_status))
        else $error("last flag does not match status flag");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_next |-> (r_rd_ptr <= last_ptr))
        else $error("drain pointer past frame length");

    a_good_xor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_clear |-> (r_xor == '0 && count_ge_len))
        else $error("drain started without a complete, clean frame");
`endif

endmodule
`default_nettype wire

### rtl/escaped_frame_receiver_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_frame_receiver_top: byte-stuffed frame receiver with XOR check
// Hunts for a guard, unescapes and buffers a fixed-length payload, checks
// the XOR sum and returns the payload plus a status, or an error status.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------
//   in      | input     | i_in_valid / o_in_stall  | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall| o_out_data (t_out_item)
//   cfg     | input     | i_cfg_wr_en              | i_cfg_wr_data (length)
//
// Outside the drain, input bytes are taken as they arrive; a byte that ends a
// frame or raises an error waits while the output register holds an untaken
// result. A good frame drains its payload as a registered read of the payload
// memory and then an output of each byte, followed by the ok status; input is
// held off for the drain.
// Output stalls hold the drain.
// Reset is synchronous; it clears the phase, count, XOR and output valid and
// sets the length to one. Payload memory contents are not reset.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_top
    import efr_pkg::*;
#(
    parameter int MAX_PAYLOAD = EFR_MAX_PAYLOAD
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_wr_en,
    input  wire  [LEN_W-1:0] i_cfg_wr_data,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output t_out_item        o_out_data
);

    t_ctrl_cmd  cmd;
    t_ctrl_stat stat;

    efr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    efr_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

endmodule
`default_nettype wire
